@@ hdl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg
// shared widths, microcode word layout and control program of the resampler
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int STAMP_W  = 27;
    localparam int SAMPLE_W = 17;
    localparam int SPAN_W   = STAMP_W + 1;        // span with a zero sign bit
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int P1_W     = SAMPLE_W + SPAN_W;
    localparam int P2_W     = DIFF_W + SPAN_W;
    localparam int NUM_W    = P2_W + 1;
    localparam int QUO_W    = SAMPLE_W;
    localparam int REM_W    = STAMP_W + QUO_W;
    localparam int DCNT_W   = $clog2(QUO_W);
    localparam int PC_W     = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_READ,
        OP_SHIFT_READ,
        OP_PREP,
        OP_MUL,
        OP_SUM,
        OP_ABS,
        OP_DIV,
        OP_EMIT_Q,
        OP_EMIT_X
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_IS_LOAD,
        C_FEW,
        C_BRACKET,
        C_SCAN_ON,
        C_EXACT,
        C_DIV_MORE,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond jmp;     // jump to target when true
        t_cond rpt;     // hold this step when true, checked first
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic no_req;
        logic is_load;
        logic few;
        logic bracket;
        logic scan_on;
        logic exact;
        logic div_more;
        logic out_full;
    } t_flags;

    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_DISPATCH = 4'd1;
    localparam t_pc PC_Q_START  = 4'd2;
    localparam t_pc PC_Q_PRIME  = 4'd3;
    localparam t_pc PC_SCAN     = 4'd4;
    localparam t_pc PC_NO_HIT   = 4'd5;
    localparam t_pc PC_FOUND    = 4'd6;
    localparam t_pc PC_MUL      = 4'd7;
    localparam t_pc PC_SUM      = 4'd8;
    localparam t_pc PC_ABS      = 4'd9;
    localparam t_pc PC_DIV      = 4'd10;
    localparam t_pc PC_EMIT_Q   = 4'd11;
    localparam t_pc PC_EMIT_X   = 4'd12;
    localparam t_pc PC_LOAD     = 4'd13;

    function automatic t_uword uprog(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:     w = '{OP_ACCEPT,     C_NEVER,   C_NO_REQ,   PC_IDLE};
            PC_DISPATCH: w = '{OP_NONE,       C_IS_LOAD, C_NEVER,    PC_LOAD};
            PC_Q_START:  w = '{OP_READ,       C_FEW,     C_NEVER,    PC_IDLE};
            PC_Q_PRIME:  w = '{OP_SHIFT_READ, C_NEVER,   C_NEVER,    PC_IDLE};
            PC_SCAN:     w = '{OP_SHIFT_READ, C_BRACKET, C_SCAN_ON,  PC_FOUND};
            PC_NO_HIT:   w = '{OP_NONE,       C_ALWAYS,  C_NEVER,    PC_IDLE};
            PC_FOUND:    w = '{OP_PREP,       C_EXACT,   C_NEVER,    PC_EMIT_X};
            PC_MUL:      w = '{OP_MUL,        C_NEVER,   C_NEVER,    PC_IDLE};
            PC_SUM:      w = '{OP_SUM,        C_NEVER,   C_NEVER,    PC_IDLE};
            PC_ABS:      w = '{OP_ABS,        C_NEVER,   C_NEVER,    PC_IDLE};
            PC_DIV:      w = '{OP_DIV,        C_NEVER,   C_DIV_MORE, PC_IDLE};
            PC_EMIT_Q:   w = '{OP_EMIT_Q,     C_ALWAYS,  C_OUT_FULL, PC_IDLE};
            PC_EMIT_X:   w = '{OP_EMIT_X,     C_ALWAYS,  C_OUT_FULL, PC_IDLE};
            PC_LOAD:     w = '{OP_LOAD,       C_ALWAYS,  C_NEVER,    PC_IDLE};
            default:     w = '{OP_NONE,       C_ALWAYS,  C_NEVER,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/lr_store.sv @@
// ----------------------------------------------------------------------------
// lr_store
// point memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module lr_store #(
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [lr_pkg::STAMP_W-1:0]        i_wtime,
    input  logic signed [lr_pkg::SAMPLE_W-1:0] i_wsample,
    input  logic                              i_re,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [lr_pkg::STAMP_W-1:0]        o_rtime,
    output logic signed [lr_pkg::SAMPLE_W-1:0] o_rsample
);
    import lr_pkg::*;

    logic [STAMP_W-1:0]         r_times   [DEPTH];
    logic signed [SAMPLE_W-1:0] r_samples [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_times[i_waddr]   <= i_wtime;
            r_samples[i_waddr] <= i_wsample;
        end
        if (i_re) begin
            o_rtime   <= r_times[i_raddr];
            o_rsample <= r_samples[i_raddr];
        end
    end

endmodule

@@ hdl/lr_useq.sv @@
// ----------------------------------------------------------------------------
// lr_useq
// step counter and control store with conditional repeat and jump
// ----------------------------------------------------------------------------
module lr_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lr_pkg::t_flags i_flags,
    output lr_pkg::t_uword o_uword
);
    import lr_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;

    function automatic logic cond_true(input t_cond c, input t_flags f);
        logic v;
        unique case (c)
            C_NEVER:    v = 1'b0;
            C_ALWAYS:   v = 1'b1;
            C_NO_REQ:   v = f.no_req;
            C_IS_LOAD:  v = f.is_load;
            C_FEW:      v = f.few;
            C_BRACKET:  v = f.bracket;
            C_SCAN_ON:  v = f.scan_on;
            C_EXACT:    v = f.exact;
            C_DIV_MORE: v = f.div_more;
            C_OUT_FULL: v = f.out_full;
            default:    v = 1'b0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_word = uprog(r_pc);
        priority if (cond_true(w_word.rpt, i_flags)) begin
            n_pc = r_pc;
        end else if (cond_true(w_word.jmp, i_flags)) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_word;

endmodule

@@ hdl/lr_dpath.sv @@
// ----------------------------------------------------------------------------
// lr_dpath
// point store, pair registers, multipliers, serial divider, result register
// ----------------------------------------------------------------------------
module lr_dpath #(
    parameter int MAX_POINTS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lr_pkg::t_uword                     i_uword,
    output lr_pkg::t_flags                     o_flags,
    input  logic                               i_in_valid,
    input  logic                               i_kind,
    input  logic                               i_first_point,
    input  logic [lr_pkg::STAMP_W-1:0]         i_stamp,
    input  logic signed [lr_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [lr_pkg::SAMPLE_W-1:0] o_value,
    output logic                               o_exact_hit
);
    import lr_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic                       r_kind;
    logic                       r_first;
    logic [STAMP_W-1:0]         r_t;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;
    logic [STAMP_W-1:0]         r_tl;
    logic [STAMP_W-1:0]         r_tr;
    logic signed [SAMPLE_W-1:0] r_yl;
    logic signed [SAMPLE_W-1:0] r_yr;
    logic [STAMP_W-1:0]         r_span;
    logic [STAMP_W-1:0]         r_u;
    logic signed [DIFF_W-1:0]   r_d;
    logic signed [P1_W-1:0]     r_p1;
    logic signed [P2_W-1:0]     r_p2;
    logic signed [NUM_W-1:0]    r_num;
    logic                       r_neg;
    logic [REM_W-1:0]           r_rem;
    logic [REM_W-1:0]           r_dvs;
    logic [QUO_W-1:0]           r_quo;
    logic [DCNT_W-1:0]          r_dcnt;
    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_value;
    logic                       r_o_hit;

    logic                       w_accept;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic                       w_re;
    logic [STAMP_W-1:0]         w_rtime;
    logic signed [SAMPLE_W-1:0] w_rsample;
    logic                       w_bracket;
    logic                       w_last;
    logic                       w_out_full;
    logic signed [SPAN_W-1:0]   w_span_s;
    logic signed [SPAN_W-1:0]   w_u_s;
    logic signed [P1_W-1:0]     w_p1;
    logic signed [P2_W-1:0]     w_p2;
    logic [NUM_W-1:0]           w_mag;
    logic                       w_ge;
    logic [QUO_W-1:0]           w_quo_s;

    assign w_accept   = (i_uword.op == OP_ACCEPT) && i_in_valid;
    assign w_we       = (i_uword.op == OP_LOAD) && (r_first || (r_count < CW'(MAX_POINTS)));
    assign w_waddr    = r_first ? '0 : r_count[AW-1:0];
    assign w_re       = (i_uword.op == OP_READ) || (i_uword.op == OP_SHIFT_READ);
    assign w_out_full = r_o_valid && i_out_stall;

    lr_store #(
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wtime   (r_t),
        .i_wsample (r_smp),
        .i_re      (w_re),
        .i_raddr   (r_idx[AW-1:0]),
        .o_rtime   (w_rtime),
        .o_rsample (w_rsample)
    );

    // pair under test: left is the held right point, right is the fresh read
    assign w_bracket = (r_t >= r_tr) && (r_t <= w_rtime);
    assign w_last    = (r_idx == r_count);

    always_comb begin
        o_flags.no_req   = !i_in_valid;
        o_flags.is_load  = !r_kind;
        o_flags.few      = r_count < CW'(2);
        o_flags.bracket  = w_bracket;
        o_flags.scan_on  = !w_bracket && !w_last;
        o_flags.exact    = (r_t == r_tl) || (r_t == r_tr);
        o_flags.div_more = r_dcnt != '0;
        o_flags.out_full = w_out_full;
    end

    assign w_span_s = $signed({1'b0, r_span});
    assign w_u_s    = $signed({1'b0, r_u});
    assign w_p1     = r_yl * w_span_s;
    assign w_p2     = r_d * w_u_s;
    assign w_mag    = r_num[NUM_W-1] ? NUM_W'(-r_num) : r_num;
    assign w_ge     = r_rem >= r_dvs;
    assign w_quo_s  = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_uword.op == OP_LOAD) begin
                if (r_first) begin
                    r_count <= CW'(1);
                end else if (r_count < CW'(MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (((i_uword.op == OP_EMIT_Q) || (i_uword.op == OP_EMIT_X)) && !w_out_full) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_uword.op)
            OP_ACCEPT: begin
                if (w_accept) begin
                    r_kind  <= i_kind;
                    r_first <= i_first_point;
                    r_t     <= i_stamp;
                    r_smp   <= i_sample_value;
                    r_idx   <= '0;
                end
            end
            OP_READ: begin
                r_idx <= r_idx + 1'b1;
            end
            OP_SHIFT_READ: begin
                r_idx <= r_idx + 1'b1;
                r_tl  <= r_tr;
                r_yl  <= r_yr;
                r_tr  <= w_rtime;
                r_yr  <= w_rsample;
            end
            OP_PREP: begin
                r_span <= r_tr - r_tl;
                r_u    <= r_t - r_tl;
                r_d    <= DIFF_W'(r_yr) - DIFF_W'(r_yl);
            end
            OP_MUL: begin
                r_p1 <= w_p1;
                r_p2 <= w_p2;
            end
            OP_SUM: begin
                r_num <= NUM_W'(r_p1) + NUM_W'(r_p2);
            end
            OP_ABS: begin
                r_neg  <= r_num[NUM_W-1];
                r_rem  <= w_mag[REM_W-1:0];
                r_dvs  <= REM_W'({r_span, {(QUO_W-1){1'b0}}});
                r_quo  <= '0;
                r_dcnt <= DCNT_W'(QUO_W - 1);
            end
            OP_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                r_dvs  <= r_dvs >> 1;
                r_dcnt <= r_dcnt - 1'b1;
            end
            OP_EMIT_Q: begin
                if (!w_out_full) begin
                    r_o_value <= $signed(w_quo_s);
                    r_o_hit   <= 1'b0;
                end
            end
            OP_EMIT_X: begin
                if (!w_out_full) begin
                    r_o_value <= (r_t == r_tr) ? r_yr : r_yl;
                    r_o_hit   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_value     = r_o_value;
    assign o_exact_hit = r_o_hit;

endmodule

@@ hdl/linear_resampler.sv @@
// ----------------------------------------------------------------------------
// linear_resampler
// piecewise linear resampling of timestamped Q9.8 samples onto query times
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------------
//  in        request    i_in_valid / o_in_stall   i_kind i_first_point i_stamp
//                                                 i_sample_value
//  out       result     o_out_valid / i_out_stall o_value o_exact_hit
//
//  a load passes the dispatch and load steps before the next request is taken
//  a query scans the point memory (one entry a cycle) and, unless it hits a
//    stored time exactly, runs the 17-step shift-subtract divider
//  reset clears the point count and the result valid flag; memory is not cleared
//  a stalled result holds the sequencer at its emit step, one result waits
//    in the output register while the next request is already being worked
//
// ----------------------------------------------------------------------------
module linear_resampler #(
    parameter int MAX_POINTS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic                               i_first_point,
    input  logic [lr_pkg::STAMP_W-1:0]         i_stamp,
    input  logic signed [lr_pkg::SAMPLE_W-1:0] i_sample_value,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lr_pkg::SAMPLE_W-1:0] o_value,
    output logic                               o_exact_hit
);
    import lr_pkg::*;

    // current control word and the status it branches on
    t_uword w_uword;
    t_flags w_flags;

    // sequencer: step counter over the control program
    lr_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    // datapath: store, scan registers, interpolation arithmetic, result register
    lr_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uword        (w_uword),
        .o_flags        (w_flags),
        .i_in_valid     (i_in_valid),
        .i_kind         (i_kind),
        .i_first_point  (i_first_point),
        .i_stamp        (i_stamp),
        .i_sample_value (i_sample_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_value        (o_value),
        .o_exact_hit    (o_exact_hit)
    );

    // requests are taken only at the idle step of the program
    assign o_in_stall = (w_uword.op != OP_ACCEPT);

endmodule

@@ hdl/lr_checker.sv @@
// ----------------------------------------------------------------------------
// lr_checker
// port-level checks on request and result timing of the resampler
// ----------------------------------------------------------------------------
module lr_assertions (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [lr_pkg::SAMPLE_W-1:0] o_value,
    input logic                               o_exact_hit
);
    import lr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value) && $stable(o_exact_hit))
        else $error("result changed while stalled");

    // a taken request holds off the next one through the dispatch step and the load or first query step
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("request taken too soon after the previous one");

    // a new result is loaded only from a busy step
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind linear_resampler lr_assertions u_lr_assertions (.*);
